/* design/ppl_pkg.sv */
// Shared types and constants for the PIN/PUK lockout engine.
// No dependencies; the top and ppl_core refer to it by scoped names.
package ppl_pkg;

  typedef enum logic [2:0] {
    OpCheckPin  = 3'd0,
    OpCheckPuk  = 3'd1,
    OpSetPin    = 3'd2,
    OpSetPuk    = 3'd3,
    OpSetStatus = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StAbsent = 2'd0,
    StReady  = 2'd1,
    StPin    = 2'd2,
    StPuk    = 2'd3
  } status_e;

  // Codes are big-endian ASCII: first character in the top byte.
  localparam logic [31:0] RESET_PIN = 32'h3030_3030;          // "0000"
  localparam logic [63:0] RESET_PUK = 64'h3132_3334_3536_3738; // "12345678"

  localparam logic [3:0] PIN_LIMIT = 4'd3;
  localparam logic [3:0] PUK_LIMIT = 4'd6;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic       accepted;
    status_e    card_status;
    logic [3:0] fail_count;
  } res_t;

endpackage

/* design/ppl_cmd_if.sv */
// Command channel: valid/ready handshake carrying one lockout command.
// No dependencies.
interface ppl_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] pin_code;
  logic [63:0] puk_code;
  logic [1:0]  new_status;

  modport source (output valid, output opcode, output pin_code, output puk_code,
                  output new_status, input ready);
  modport sink (input valid, input opcode, input pin_code, input puk_code,
                input new_status, output ready);
endinterface

/* design/ppl_res_if.sv */
// Result channel: valid/ready handshake carrying one command outcome.
// No dependencies.
interface ppl_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] card_status;
  logic [3:0] fail_count;

  modport source (output valid, output accepted, output card_status,
                  output fail_count, input ready);
  modport sink (input valid, input accepted, input card_status,
                input fail_count, output ready);
endinterface

/* design/pin_puk_lockout_fsm_top.sv */
// Channel    | Dir | Payload
// cmd_i      | in  | opcode, pin_code, puk_code, new_status
// res_o      | out | accepted, card_status, fail_count
//
// One command per cycle while cmd_i.ready is high: the state update is a code
// compare plus a counter step, done in the cycle the command is taken; the
// result goes to the output register on the result side, or to the skid
// register while the output still holds one, so a command is still taken while
// one result waits; cmd_i.ready drops only when both hold results. Reset
// restores status ready, PIN "0000", PUK "12345678" and a zero counter.
// Depends on ppl_pkg, ppl_cmd_if, ppl_res_if and ppl_core.
module pin_puk_lockout_fsm_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  ppl_cmd_if.sink   cmd_i,
  ppl_res_if.source res_o
);

  ppl_pkg::res_t res_new;
  ppl_pkg::res_t out_q, out_d;
  ppl_pkg::res_t skid_q, skid_d;
  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  logic          cmd_fire, res_fire;

  assign cmd_i.ready = !skid_valid_q;
  assign cmd_fire    = cmd_i.valid && !skid_valid_q;
  assign res_fire    = out_valid_q && res_o.ready;

  ppl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (cmd_fire),
    .opcode_i     (cmd_i.opcode),
    .pin_code_i   (cmd_i.pin_code),
    .puk_code_i   (cmd_i.puk_code),
    .new_status_i (cmd_i.new_status),
    .res_o        (res_new)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // advance the waiting transaction once the output drains
      if (res_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (cmd_fire) begin
      if (!out_valid_q || res_fire) begin
        out_d       = res_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_new;
        skid_valid_d = 1'b1;
      end
    end else if (res_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.accepted    = out_q.accepted;
  assign res_o.card_status = out_q.card_status;
  assign res_o.fail_count  = out_q.fail_count;

endmodule

/* design/ppl_core.sv */
// Card state (status, PIN, PUK, retry counter) and its registered update on each fired command.
// Depends on ppl_pkg.
module ppl_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [2:0]      opcode_i,
  input  logic [31:0]     pin_code_i,
  input  logic [63:0]     puk_code_i,
  input  logic [1:0]      new_status_i,
  output ppl_pkg::res_t   res_o
);

  ppl_pkg::status_e status_q, status_d;
  logic [31:0]      pin_q, pin_d;
  logic [63:0]      puk_q, puk_d;
  logic [3:0]       count_q, count_d;
  logic [3:0]       count_inc;
  logic             ok;

  assign count_inc = (count_q == ppl_pkg::COUNT_MAX) ? count_q : count_q + 4'd1;

  always_comb begin
    status_d = status_q;
    pin_d    = pin_q;
    puk_d    = puk_q;
    count_d  = count_q;
    ok       = 1'b0;
    case (ppl_pkg::op_e'(opcode_i))
      ppl_pkg::OpCheckPin: begin
        if (status_q == ppl_pkg::StPin || status_q == ppl_pkg::StReady) begin
          if (pin_code_i == pin_q) begin
            status_d = ppl_pkg::StReady;
            count_d  = 4'd0;
            ok       = 1'b1;
          end else if (status_q == ppl_pkg::StPin) begin
            count_d = count_inc;
            // lock to PUK only when the increment lands on the limit
            if (count_inc == ppl_pkg::PIN_LIMIT) begin
              status_d = ppl_pkg::StPuk;
            end
          end
        end
      end
      ppl_pkg::OpCheckPuk: begin
        if (status_q == ppl_pkg::StPuk) begin
          if (puk_code_i == puk_q) begin
            pin_d    = pin_code_i;
            status_d = ppl_pkg::StReady;
            count_d  = 4'd0;
            ok       = 1'b1;
          end else begin
            count_d = count_inc;
            if (count_inc == ppl_pkg::PUK_LIMIT) begin
              status_d = ppl_pkg::StAbsent;
            end
          end
        end
      end
      ppl_pkg::OpSetPin: begin
        pin_d   = pin_code_i;
        count_d = 4'd0;
      end
      ppl_pkg::OpSetPuk: begin
        puk_d   = puk_code_i;
        count_d = 4'd0;
      end
      ppl_pkg::OpSetStatus: begin
        status_d = ppl_pkg::status_e'(new_status_i);
      end
      default: begin
      end
    endcase
  end

  assign res_o.accepted    = ok;
  assign res_o.card_status = status_d;
  assign res_o.fail_count  = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ppl_pkg::StReady;
      pin_q    <= ppl_pkg::RESET_PIN;
      puk_q    <= ppl_pkg::RESET_PUK;
      count_q  <= 4'd0;
    end else if (fire_i) begin
      status_q <= status_d;
      pin_q    <= pin_d;
      puk_q    <= puk_d;
      count_q  <= count_d;
    end
  end

endmodule
